// File: hw/rtl/sacd_pkg.sv
// ----------------------------------------------------------------------------
// sacd_pkg - shared types and constants of the cache directory
// Geometry, entry and row layouts, op and status codes.
// ----------------------------------------------------------------------------
package sacd_pkg;

  // Geometry. NUM_SETS is a power of two: the set is the low key bits.
  localparam int NUM_SETS   = 16;
  localparam int WAYS       = 4;
  localparam int STAMP_BITS = 16;

  localparam int SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Fixed port widths
  localparam int KEY_BITS     = 32;
  localparam int OP_BITS      = 3;
  localparam int SEL_BITS     = 4;
  localparam int WSEL_BITS    = 2;
  localparam int STATUS_BITS  = 3;
  localparam int WAY_OUT_BITS = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_GET_READ        = 3'd0,
    OP_GET_WRITE       = 3'd1,
    OP_PUTBACK_KEEP    = 3'd2,
    OP_PUTBACK_DISCARD = 3'd3,
    OP_FLUSH_SET       = 3'd4
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_NOFREE    = 3'd2,
    ST_BUSY_WAIT = 3'd3,
    ST_WRITEBACK = 3'd4,
    ST_DONE      = 3'd5
  } status_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   tag;
    logic                  valid;
    logic                  busy;
    logic                  dirty;
    logic [STAMP_BITS-1:0] stamp;
  } way_ent_t;

  typedef struct packed {
    way_ent_t [WAYS-1:0]   ways;
    logic [STAMP_BITS-1:0] counter;
  } set_row_t;

  // Memory port request from the controller
  typedef struct packed {
    logic                rd_en;
    logic [SET_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [SET_BITS-1:0] wr_addr;
  } mem_req_t;

  // Lookup and victim choice over one row
  typedef struct packed {
    logic                hit;
    logic                hit_busy;
    logic [WAY_BITS-1:0] hit_way;
    logic                found;
    logic [WAY_BITS-1:0] victim;
  } pick_t;

endpackage

// File: hw/rtl/set_assoc_lru_cache_directory_core.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_directory_core - set-associative LRU cache directory
// Gets look up or refill a way, putbacks release one, flushes clean a set.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                          Handshake
// --------  -----------------------------------------------  ----------------
// command   op key set_sel way_sel mark_dirty                 start & !busy
// result    status way need_writeback victim_key              strobe, 1 cycle
//           counter_wrapped last
//
// An item is taken in the cycle start is high and busy low; the set's row is
// read from the directory memory at that edge. The next cycle evaluates the
// row and writes it back if it changes, and the result of a get, putback or
// unused op shows in the cycle after. A flush instead moves to its scan state
// and gives one result per cycle from its scan register: a writeback for each
// way that is written back, then a final done. busy is low again while the
// final result is shown. Reset is synchronous and clears the row valid bits,
// so every set reads as zero until first written. Results cannot be stalled.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_directory_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [sacd_pkg::OP_BITS-1:0]        op,
  input  logic [sacd_pkg::KEY_BITS-1:0]       key,
  input  logic [sacd_pkg::SEL_BITS-1:0]       set_sel,
  input  logic [sacd_pkg::WSEL_BITS-1:0]      way_sel,
  input  logic                                mark_dirty,
  output logic                                strobe,
  output logic [sacd_pkg::STATUS_BITS-1:0]    status,
  output logic [sacd_pkg::WAY_OUT_BITS-1:0]   way,
  output logic                                need_writeback,
  output logic [sacd_pkg::KEY_BITS-1:0]       victim_key,
  output logic                                counter_wrapped,
  output logic                                last
);
  import sacd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  function automatic logic [WAY_OUT_BITS-1:0] way_out(input logic [WAY_BITS-1:0] w);
    logic [31:0] t;
    t = 32'(w);
    return t[WAY_OUT_BITS-1:0];
  endfunction

  state_t state, state_next;

  // captured item
  logic [OP_BITS-1:0]  op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [SET_BITS-1:0] addr_q;
  logic [WAY_BITS-1:0] way_q;
  logic                set_ok_q;
  logic                way_ok_q;
  logic                mark_q;

  // flush scan
  logic [WAYS-1:0] wb_mask, wb_mask_next;
  logic [WAYS-1:0] flush_clr, flush_clr_next;

  // memory side
  mem_req_t req;
  set_row_t rd_row;
  set_row_t wr_row;
  pick_t    pick;

  // result to register
  logic                    res_en;
  status_t                 res_status;
  logic [WAY_OUT_BITS-1:0] res_way;
  logic                    res_wb;
  logic [KEY_BITS-1:0]     res_vkey;
  logic                    res_wrap;
  logic                    res_last;

  logic                  accept;
  logic [31:0]           sel_ext;
  logic [31:0]           wsel_ext;
  logic [SET_BITS-1:0]   in_addr;
  logic [STAMP_BITS-1:0] cnt_inc;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign sel_ext  = 32'(set_sel);
  assign wsel_ext = 32'(way_sel);
  assign in_addr  = (op == OP_GET_READ || op == OP_GET_WRITE) ?
                    key[SET_BITS-1:0] : sel_ext[SET_BITS-1:0];

  sacd_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .wr_data (wr_row),
    .rd_data (rd_row)
  );

  sacd_pick u_pick (
    .row  (rd_row),
    .key  (key_q),
    .pick (pick)
  );

  assign cnt_inc = rd_row.counter + 1'b1;

  always_comb begin
    logic            wr;
    logic [WAYS-1:0] cond;
    logic [WAY_BITS-1:0] fw;
    state_next     = state;
    wb_mask_next   = wb_mask;
    flush_clr_next = flush_clr;
    wr_row         = rd_row;
    wr             = 1'b0;
    res_en         = 1'b0;
    res_status     = ST_DONE;
    res_way        = '0;
    res_wb         = 1'b0;
    res_vkey       = '0;
    res_wrap       = 1'b0;
    res_last       = 1'b1;
    fw             = '0;
    for (int w = 0; w < WAYS; w++) begin
      cond[w] = !rd_row.ways[w].busy && rd_row.ways[w].valid && rd_row.ways[w].dirty;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end

      S_EVAL: begin
        state_next = S_IDLE;
        res_en     = 1'b1;
        case (op_q)
          OP_GET_READ, OP_GET_WRITE: begin
            if (pick.hit) begin
              res_way = way_out(pick.hit_way);
              if (pick.hit_busy) begin
                res_status = ST_BUSY_WAIT;
              end else begin
                res_status     = ST_HIT;
                res_wrap       = (cnt_inc == '0);
                wr             = 1'b1;
                wr_row.counter = cnt_inc;
                wr_row.ways[pick.hit_way].stamp = cnt_inc;
                if (op_q == OP_GET_WRITE) begin
                  wr_row.ways[pick.hit_way].busy = 1'b1;
                end
              end
            end else if (!pick.found) begin
              res_status = ST_NOFREE;
            end else begin
              res_status = ST_MISS;
              res_way    = way_out(pick.victim);
              res_wrap   = (cnt_inc == '0);
              // a refill of a dirty valid way must save the old key first
              if (rd_row.ways[pick.victim].dirty && rd_row.ways[pick.victim].valid) begin
                res_wb   = 1'b1;
                res_vkey = rd_row.ways[pick.victim].tag;
              end
              wr             = 1'b1;
              wr_row.counter = cnt_inc;
              wr_row.ways[pick.victim].dirty = 1'b0;
              wr_row.ways[pick.victim].tag   = key_q;
              wr_row.ways[pick.victim].valid = 1'b1;
              wr_row.ways[pick.victim].stamp = cnt_inc;
              if (op_q == OP_GET_WRITE) begin
                wr_row.ways[pick.victim].busy = 1'b1;
              end
            end
          end
          OP_PUTBACK_KEEP, OP_PUTBACK_DISCARD: begin
            if (set_ok_q && way_ok_q) begin
              wr = 1'b1;
              wr_row.ways[way_q].stamp =
                (op_q == OP_PUTBACK_KEEP) ? rd_row.counter : '0;
              wr_row.ways[way_q].busy = 1'b0;
              if (mark_q) begin
                wr_row.ways[way_q].dirty = 1'b1;
              end
            end
          end
          OP_FLUSH_SET: begin
            // results come from the scan state instead
            res_en         = 1'b0;
            state_next     = S_FLUSH;
            wb_mask_next   = set_ok_q ? cond : '0;
            flush_clr_next = set_ok_q ? cond : '0;
          end
          default: begin
          end
        endcase
      end

      S_FLUSH: begin
        res_en = 1'b1;
        if (|wb_mask) begin
          for (int w = WAYS - 1; w >= 0; w--) begin
            if (wb_mask[w]) begin
              fw = WAY_BITS'(w);
            end
          end
          res_status       = ST_WRITEBACK;
          res_way          = way_out(fw);
          res_vkey         = rd_row.ways[fw].tag;
          res_last         = 1'b0;
          wb_mask_next[fw] = 1'b0;
        end else begin
          // final done: clean every way that was written back
          state_next = S_IDLE;
          wr         = |flush_clr;
          for (int w = 0; w < WAYS; w++) begin
            if (flush_clr[w]) begin
              wr_row.ways[w].dirty = 1'b0;
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    req.rd_en   = accept;
    req.rd_addr = in_addr;
    req.wr_en   = wr;
    req.wr_addr = addr_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op;
      key_q    <= key;
      addr_q   <= in_addr;
      way_q    <= wsel_ext[WAY_BITS-1:0];
      set_ok_q <= (op == OP_GET_READ || op == OP_GET_WRITE) || (sel_ext < NUM_SETS);
      way_ok_q <= (wsel_ext < WAYS);
      mark_q   <= mark_dirty;
    end
    wb_mask   <= wb_mask_next;
    flush_clr <= flush_clr_next;
    if (res_en) begin
      status          <= res_status;
      way             <= res_way;
      need_writeback  <= res_wb;
      victim_key      <= res_vkey;
      counter_wrapped <= res_wrap;
      last            <= res_last;
    end
  end

endmodule

// File: hw/rtl/sacd_store.sv
// ----------------------------------------------------------------------------
// sacd_store - directory row memory
// One row per set with a registered read; rows never written read as zero.
// ----------------------------------------------------------------------------
module sacd_store (
  input  logic                clk,
  input  logic                rst,
  input  sacd_pkg::mem_req_t  req,
  input  sacd_pkg::set_row_t  wr_data,
  output sacd_pkg::set_row_t  rd_data
);
  import sacd_pkg::*;

  set_row_t            mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_valid;
  set_row_t            rd_q;
  logic                rd_valid_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_q <= row_valid[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// File: hw/rtl/sacd_pick.sv
// ----------------------------------------------------------------------------
// sacd_pick - tag match and LRU victim choice
// Works on the registered row; the victim scan skips busy ways.
// ----------------------------------------------------------------------------
module sacd_pick (
  input  sacd_pkg::set_row_t             row,
  input  logic [sacd_pkg::KEY_BITS-1:0]  key,
  output sacd_pkg::pick_t                pick
);
  import sacd_pkg::*;

  always_comb begin
    logic                  have;
    logic                  stop;
    logic [STAMP_BITS-1:0] vic_stamp;
    pick = '0;
    have = 1'b0;
    stop = 1'b0;
    vic_stamp = '0;

    // first valid way with a matching tag
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row.ways[w].valid && row.ways[w].tag == key) begin
        pick.hit      = 1'b1;
        pick.hit_way  = WAY_BITS'(w);
        pick.hit_busy = row.ways[w].busy;
      end
    end

    // invalid first free way ends the scan; else strictly older stamp wins
    for (int w = 0; w < WAYS; w++) begin
      if (!stop && !row.ways[w].busy) begin
        if (!have) begin
          have        = 1'b1;
          pick.victim = WAY_BITS'(w);
          vic_stamp   = row.ways[w].stamp;
          if (!row.ways[w].valid) begin
            stop = 1'b1;
          end
        end else if (row.ways[w].stamp < vic_stamp) begin
          pick.victim = WAY_BITS'(w);
          vic_stamp   = row.ways[w].stamp;
        end
      end
    end
    pick.found = have;
  end

endmodule
